FILE: rtl/fcs_pkg.sv
// fcs_pkg: shared types and constants of the flash command sequencer
// no dependencies; imported by fcs_store, fcs_seq and flash_command_sequencer_top

package fcs_pkg;

   // fixed geometry
   localparam int BANK_BYTES   = 65536;
   localparam int SECTOR_BYTES = 4096;

   // bus access kind carried in tuser
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // command addresses
   localparam logic [27:0] ADDR_UNLOCK1 = 28'hE00_5555;
   localparam logic [27:0] ADDR_UNLOCK2 = 28'hE00_2AAA;
   localparam logic [27:0] ADDR_BASE    = 28'hE00_0000;

   // unlock bytes and command codes
   localparam logic [7:0] DATA_UNLOCK1     = 8'hAA;
   localparam logic [7:0] DATA_UNLOCK2     = 8'h55;
   localparam logic [7:0] CMD_ID_ENTER     = 8'h90;
   localparam logic [7:0] CMD_ID_EXIT      = 8'hF0;
   localparam logic [7:0] CMD_ERASE_ARM    = 8'h80;
   localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
   localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
   localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
   localparam logic [7:0] CMD_BANK_SELECT  = 8'hB0;

   // blank flash and chip id bytes
   localparam logic [7:0] BLANK_BYTE   = 8'hFF;
   localparam logic [7:0] ID_LARGE_MFR = 8'hC2;
   localparam logic [7:0] ID_LARGE_DEV = 8'h09;
   localparam logic [7:0] ID_SMALL_MFR = 8'hBF;
   localparam logic [7:0] ID_SMALL_DEV = 8'hD4;

   typedef enum logic [1:0] {
      PH_UNLOCK1,
      PH_UNLOCK2,
      PH_COMMAND,
      PH_EXTENDED
   } phase_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RESP,
      SEQ_SWEEP
   } seq_state_type;

   // strobes from the sequencer to the byte store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

FILE: rtl/fcs_store.sv
// fcs_store: byte-wide flash array, one write and one read port, registered read
// depends on fcs_pkg (store_ctl_type)

module fcs_store #(
   parameter int DEPTH = 131072
) (
   input  logic                      clock,
   input  fcs_pkg::store_ctl_type    ctl,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [7:0]                wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fcs_seq.sv
// fcs_seq: unlock/command protocol, id mode, erase sweeps and read path control
// depends on fcs_pkg; drives fcs_store through its control struct

module fcs_seq #(
   parameter int STORE_BYTES = 131072
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           large_size,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           opcode,
   input  logic [27:0]                    bus_address,
   input  logic [7:0]                     write_data,
   input  logic                           out_free,
   output logic                           rsp_push,
   output logic [7:0]                     rsp_data,
   output fcs_pkg::store_ctl_type         store_ctl,
   output logic [$clog2(STORE_BYTES)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output logic [$clog2(STORE_BYTES)-1:0] rd_addr,
   input  logic [7:0]                     rd_data
);

   import fcs_pkg::*;

   localparam int AW         = $clog2(STORE_BYTES);
   localparam int CW         = $clog2(STORE_BYTES + 1);
   localparam int CHIP_LARGE = (STORE_BYTES < 2 * BANK_BYTES) ? STORE_BYTES : 2 * BANK_BYTES;

   seq_state_type  state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           id_mode_ff, id_mode_in;
   logic           erase_armed_ff, erase_armed_in;
   logic           program_armed_ff, program_armed_in;
   logic           bank_armed_ff, bank_armed_in;
   logic           bank_ff, bank_in;
   logic           sweep_go_ff, sweep_go_in;
   logic [AW-1:0]  sweep_addr_ff, sweep_addr_in;
   logic [CW-1:0]  sweep_left_ff, sweep_left_in;
   logic           use_ram_ff, use_ram_in;
   logic [7:0]     const_ff, const_in;
   logic           eff_bank;
   logic           at_unlock1;
   logic           at_sector;

   // bank * 64k + low 16 bits, wrapped into the store
   function automatic logic [AW-1:0] phys(input logic b, input logic [15:0] lo);
      logic [17:0] raw;
      raw = {1'b0, b, lo};
      if (raw >= 18'(STORE_BYTES)) begin
         raw = raw - 18'(STORE_BYTES);
      end
      return AW'(raw);
   endfunction

   assign eff_bank   = large_size & bank_ff;
   assign at_unlock1 = (bus_address == ADDR_UNLOCK1);
   assign at_sector  = (bus_address[27:16] == ADDR_BASE[27:16]) &&
                       (bus_address[11:0] == ADDR_BASE[11:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= SEQ_SWEEP;
         phase_ff         <= PH_UNLOCK1;
         id_mode_ff       <= 1'b0;
         erase_armed_ff   <= 1'b0;
         program_armed_ff <= 1'b0;
         bank_armed_ff    <= 1'b0;
         bank_ff          <= 1'b0;
         sweep_go_ff      <= 1'b0;
         sweep_addr_ff    <= '0;
         sweep_left_ff    <= CW'(STORE_BYTES);
         use_ram_ff       <= 1'b0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         id_mode_ff       <= id_mode_in;
         erase_armed_ff   <= erase_armed_in;
         program_armed_ff <= program_armed_in;
         bank_armed_ff    <= bank_armed_in;
         bank_ff          <= bank_in;
         sweep_go_ff      <= sweep_go_in;
         sweep_addr_ff    <= sweep_addr_in;
         sweep_left_ff    <= sweep_left_in;
         use_ram_ff       <= use_ram_in;
      end
   end

   always_ff @(posedge clock) begin
      const_ff <= const_in;
   end

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      id_mode_in       = id_mode_ff;
      erase_armed_in   = erase_armed_ff;
      program_armed_in = program_armed_ff;
      bank_armed_in    = bank_armed_ff;
      bank_in          = bank_ff;
      sweep_go_in      = sweep_go_ff;
      sweep_addr_in    = sweep_addr_ff;
      sweep_left_in    = sweep_left_ff;
      use_ram_in       = use_ram_ff;
      const_in         = const_ff;
      req_tready       = 1'b0;
      rsp_push         = 1'b0;
      rsp_data         = use_ram_ff ? rd_data : const_ff;
      store_ctl        = '0;
      wr_addr          = sweep_addr_ff;
      wr_data          = BLANK_BYTE;
      rd_addr          = phys(eff_bank, bus_address[15:0]);

      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in    = SEQ_RESP;
               sweep_go_in = 1'b0;
               use_ram_in  = 1'b0;
               const_in    = '0;
               if (opcode == OP_READ) begin
                  if (id_mode_ff && (bus_address[15:1] == '0)) begin
                     if (large_size) begin
                        const_in = bus_address[0] ? ID_LARGE_DEV : ID_LARGE_MFR;
                     end else begin
                        const_in = bus_address[0] ? ID_SMALL_DEV : ID_SMALL_MFR;
                     end
                  end else begin
                     use_ram_in    = 1'b1;
                     store_ctl.rd_en = 1'b1;
                  end
               end else begin
                  case (phase_ff)
                     PH_UNLOCK1: begin
                        if (at_unlock1 && (write_data == DATA_UNLOCK1)) begin
                           phase_in = PH_UNLOCK2;
                        end
                     end
                     PH_UNLOCK2: begin
                        if ((bus_address == ADDR_UNLOCK2) && (write_data == DATA_UNLOCK2)) begin
                           phase_in = PH_COMMAND;
                        end
                     end
                     PH_COMMAND: begin
                        if (at_unlock1) begin
                           case (write_data)
                              CMD_ID_ENTER: begin
                                 id_mode_in = 1'b1;
                                 phase_in   = PH_UNLOCK1;
                              end
                              CMD_ID_EXIT: begin
                                 id_mode_in = 1'b0;
                                 phase_in   = PH_UNLOCK1;
                              end
                              CMD_ERASE_ARM: begin
                                 erase_armed_in = 1'b1;
                                 phase_in       = PH_UNLOCK1;
                              end
                              CMD_CHIP_ERASE: begin
                                 if (erase_armed_ff) begin
                                    erase_armed_in = 1'b0;
                                    sweep_go_in    = 1'b1;
                                    sweep_addr_in  = '0;
                                    sweep_left_in  = large_size ? CW'(CHIP_LARGE)
                                                                : CW'(BANK_BYTES);
                                 end
                                 phase_in = PH_UNLOCK1;
                              end
                              CMD_PROGRAM: begin
                                 program_armed_in = 1'b1;
                                 phase_in         = PH_EXTENDED;
                              end
                              CMD_BANK_SELECT: begin
                                 if (large_size) begin
                                    bank_armed_in = 1'b1;
                                    phase_in      = PH_EXTENDED;
                                 end else begin
                                    phase_in = PH_UNLOCK1;
                                 end
                              end
                              default: begin
                              end
                           endcase
                        end else if (erase_armed_ff && at_sector &&
                                     (write_data == CMD_SECTOR_ERASE)) begin
                           erase_armed_in = 1'b0;
                           sweep_go_in    = 1'b1;
                           sweep_addr_in  = phys(eff_bank, {bus_address[15:12], 12'h000});
                           sweep_left_in  = CW'(SECTOR_BYTES);
                           phase_in       = PH_UNLOCK1;
                        end
                     end
                     PH_EXTENDED: begin
                        if (program_armed_ff) begin
                           store_ctl.wr_en  = 1'b1;
                           wr_addr          = phys(eff_bank, bus_address[15:0]);
                           wr_data          = write_data;
                           program_armed_in = 1'b0;
                        end else if (bank_armed_ff && (bus_address == ADDR_BASE)) begin
                           bank_in       = write_data[0];
                           bank_armed_in = 1'b0;
                        end
                        phase_in = PH_UNLOCK1;
                     end
                     default: begin
                        phase_in = PH_UNLOCK1;
                     end
                  endcase
               end
            end
         end
         SEQ_RESP: begin
            if (out_free) begin
               rsp_push = 1'b1;
               state_in = sweep_go_ff ? SEQ_SWEEP : SEQ_IDLE;
            end
         end
         SEQ_SWEEP: begin
            store_ctl.wr_en = 1'b1;
            sweep_go_in     = 1'b0;
            sweep_addr_in   = (sweep_addr_ff == AW'(STORE_BYTES - 1)) ? '0
                                                                     : sweep_addr_ff + 1'b1;
            sweep_left_in   = sweep_left_ff - 1'b1;
            if (sweep_left_ff == CW'(1)) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   a_one_push_per_item: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> !rsp_push)
      else $error("two results pushed back to back");

   a_accept_to_resp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == SEQ_RESP))
      else $error("accepted word did not move to response");

   a_program_in_extended: assert property (@(posedge clock) disable iff (reset)
      (store_ctl.wr_en && (state_ff == SEQ_IDLE)) |-> (phase_ff == PH_EXTENDED))
      else $error("byte program outside extended phase");

   a_sweep_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SWEEP) |-> (sweep_left_ff != '0))
      else $error("erase sweep running with zero length");

endmodule

FILE: rtl/flash_command_sequencer_top.sv
// flash_command_sequencer_top: stream wrapper, size register and response buffer
// depends on fcs_pkg, fcs_store and fcs_seq

// Byte-wide flash save memory behind an unlock/command protocol.
// req channel: one bus access per word; tuser is the kind (0 read, 1 write),
//   tdata holds the 28-bit bus address and the write byte.
// rsp channel: one word per accepted request; the byte read, zero for a write.
// csr port: csr_wr_en writes large_size (0 = 64 KiB, 1 = 128 KiB two banks).
// Response: the store read is registered, then the response state of the sequencer
//   pushes the byte into the output register that drives rsp_tvalid. A further
//   request is taken only once that push is done; a full output register delays it.
// Erase: after its response a sector erase holds req_tready low while it sweeps
//   its 4096 bytes, a chip erase while it sweeps 65536 (small) or 131072 (large)
//   bytes; the sweep writes one byte per cycle through the single store write port.
// Reset: control state clears and the store is swept to 0xFF, all STORE_BYTES
//   bytes, during which no request is accepted; large_size resets to 1.
// Stall: a finished response waits in the output register; one further
//   request may be taken meanwhile, its response waiting until rsp_tready.

module flash_command_sequencer_top #(
   parameter int STORE_BYTES = 131072
) (
   input  logic        clock,
   input  logic        reset,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // bus_address [27:0], write_data [35:28], zero [39:36]
   input  logic [0:0]  req_tuser,   // opcode [0]
   // responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // read_data [7:0]
   // size register
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   import fcs_pkg::*;

   localparam int AW = $clog2(STORE_BYTES);

   logic          large_size_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          out_free;
   logic          rsp_push;
   logic [7:0]    rsp_data;
   store_ctl_type store_ctl;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // size register, to be written by the user only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         large_size_ff <= 1'b1;
      end else if (csr_wr_en) begin
         large_size_ff <= csr_wr_data;
      end
   end

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // protocol sequencer and sweep control
   fcs_seq #(
      .STORE_BYTES (STORE_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .large_size  (large_size_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .opcode      (req_tuser[0]),
      .bus_address (req_tdata[27:0]),
      .write_data  (req_tdata[35:28]),
      .out_free    (out_free),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_data),
      .store_ctl   (store_ctl),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   // flash byte array
   fcs_store #(
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> out_free)
      else $error("response pushed into a full output register");

endmodule
